@@ hdl/bpfa_pkg.sv @@
// Package with shared types and constants of the bitmap page frame allocator.
package bpfa_pkg;

    localparam int DIR_ENTRIES = 1024;
    localparam int DIR_W = 10;
    localparam int PAGE_SHIFT = 12;
    localparam logic [31:0] PAGE_MASK = 32'hffff_f000;
    localparam logic [31:0] ENTRY_FLAGS = 32'h0000_0007;
    localparam logic [31:0] KERNEL_PHYS_RESET = 32'h0020_0000;

    localparam logic [2:0] CFG_KERNEL_PHYS_BASE = 3'd0;
    localparam logic [2:0] CFG_USER_PHYS_BASE = 3'd1;
    localparam logic [2:0] CFG_KERNEL_VIRT_BASE = 3'd2;
    localparam logic [2:0] CFG_USER_VIRT_BASE = 3'd3;
    localparam logic [2:0] CFG_KERNEL_POOL_PAGES = 3'd4;
    localparam logic [2:0] CFG_USER_POOL_PAGES = 3'd5;
    localparam logic [2:0] CFG_USER_VIRT_PAGES = 3'd6;

    typedef enum logic [2:0] {
        ST_OK = 3'd0,
        ST_NO_RUN = 3'd1,
        ST_NO_FRAME = 3'd2,
        ST_BAD_COUNT = 3'd3,
        ST_OUTSIDE = 3'd4,
        ST_NO_TABLE = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        SK_VRUN,
        SK_DFRAME,
        SK_TFRAME
    } t_scan;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_VSCAN,
        S_VSET,
        S_DSCAN,
        S_TREAD,
        S_TCHK,
        S_TSCAN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic    clr;
        logic    load;
        logic    scan_start;
        t_scan   scan_kind;
        logic    vwr;
        logic    pg_clr;
        logic    pg_inc;
        logic    out_load;
        t_status out_st;
        logic    out_tc;
    } t_bpfa_cmd;

    typedef struct packed {
        logic clr_done;
        logic is_claim;
        logic claim_oob;
        logic bad_cnt;
        logic scan_found;
        logic scan_fail;
        logic vset_done;
        logic tpres_bit;
        logic out_last;
    } t_bpfa_stat;

endpackage

@@ hdl/bpfa_ctrl.sv @@
// Controller state machine of the bitmap page frame allocator.
module bpfa_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    output logic                o_valid,
    input  logic                i_stall,
    input  bpfa_pkg::t_bpfa_stat i_stat,
    output bpfa_pkg::t_bpfa_cmd  o_cmd
);
    import bpfa_pkg::*;

    t_state r_state, n_state;
    t_bpfa_cmd cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        cmd = '0;
        cmd.scan_kind = SK_VRUN;
        cmd.out_st = ST_OK;
        case (r_state)
            S_CLEAR: begin
                cmd.clr = 1'b1;
                if (i_stat.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    cmd.load = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_stat.is_claim) begin
                    if (i_stat.claim_oob) begin
                        cmd.out_load = 1'b1;
                        cmd.out_st = ST_OUTSIDE;
                        n_state = S_OUT;
                    end else begin
                        cmd.vwr = 1'b1;
                        cmd.pg_clr = 1'b1;
                        cmd.scan_start = 1'b1;
                        cmd.scan_kind = SK_DFRAME;
                        n_state = S_DSCAN;
                    end
                end else if (i_stat.bad_cnt) begin
                    cmd.out_load = 1'b1;
                    cmd.out_st = ST_BAD_COUNT;
                    n_state = S_OUT;
                end else begin
                    cmd.scan_start = 1'b1;
                    cmd.scan_kind = SK_VRUN;
                    n_state = S_VSCAN;
                end
            end
            S_VSCAN: begin
                if (i_stat.scan_found) begin
                    cmd.pg_clr = 1'b1;
                    n_state = S_VSET;
                end else if (i_stat.scan_fail) begin
                    cmd.out_load = 1'b1;
                    cmd.out_st = ST_NO_RUN;
                    n_state = S_OUT;
                end
            end
            S_VSET: begin
                cmd.vwr = 1'b1;
                if (i_stat.vset_done) begin
                    cmd.pg_clr = 1'b1;
                    cmd.scan_start = 1'b1;
                    cmd.scan_kind = SK_DFRAME;
                    n_state = S_DSCAN;
                end else begin
                    cmd.pg_inc = 1'b1;
                end
            end
            S_DSCAN: begin
                if (i_stat.scan_found) begin
                    n_state = S_TREAD;
                end else if (i_stat.scan_fail) begin
                    cmd.out_load = 1'b1;
                    cmd.out_st = ST_NO_FRAME;
                    n_state = S_OUT;
                end
            end
            S_TREAD: begin
                n_state = S_TCHK;
            end
            S_TCHK: begin
                if (i_stat.tpres_bit) begin
                    cmd.out_load = 1'b1;
                    cmd.out_st = ST_OK;
                    n_state = S_OUT;
                end else begin
                    cmd.scan_start = 1'b1;
                    cmd.scan_kind = SK_TFRAME;
                    n_state = S_TSCAN;
                end
            end
            S_TSCAN: begin
                if (i_stat.scan_found) begin
                    cmd.out_load = 1'b1;
                    cmd.out_st = ST_OK;
                    cmd.out_tc = 1'b1;
                    n_state = S_OUT;
                end else if (i_stat.scan_fail) begin
                    cmd.out_load = 1'b1;
                    cmd.out_st = ST_NO_TABLE;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_stall) begin
                    if (i_stat.out_last) begin
                        n_state = S_IDLE;
                    end else begin
                        cmd.pg_inc = 1'b1;
                        cmd.scan_start = 1'b1;
                        cmd.scan_kind = SK_DFRAME;
                        n_state = S_DSCAN;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd = cmd;
    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);

endmodule

@@ hdl/bpfa_dp.sv @@
// Datapath of the bitmap page frame allocator: registers, bitmaps and scan unit.
module bpfa_dp #(
    parameter int POOL_PAGES = 1024,
    parameter int MAX_RUN_PAGES = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [2:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  logic                 i_req_type,
    input  logic                 i_pool_select,
    input  logic [6:0]           i_page_count,
    input  logic [31:0]          i_target_addr,
    input  bpfa_pkg::t_bpfa_cmd  i_cmd,
    output bpfa_pkg::t_bpfa_stat o_stat,
    output logic [2:0]           o_status,
    output logic [31:0]          o_virt_addr,
    output logic [31:0]          o_phys_addr,
    output logic [31:0]          o_entry_word,
    output logic                 o_table_created,
    output logic [31:0]          o_table_entry_word,
    output logic                 o_last
);
    import bpfa_pkg::*;

    localparam int IW = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
    localparam int LW = $clog2(POOL_PAGES + 1);
    localparam int SW = (LW > 11) ? LW : 11;
    localparam int CLR_N = (POOL_PAGES > DIR_ENTRIES) ? POOL_PAGES : DIR_ENTRIES;
    localparam int CW = $clog2(CLR_N);

    logic [31:0] r_kpb, r_upb, r_kvb, r_uvb;
    logic [10:0] r_kpp, r_upp, r_uvp;

    logic        r_req, r_user;
    logic [6:0]  r_cnt, r_pg;
    logic [31:0] r_tgt, r_pa;
    logic [IW-1:0] r_start;

    logic [CW-1:0] r_clr_addr;

    logic          r_sc_act, r_sc_pv;
    logic [LW-1:0] r_sc_addr;
    logic [IW-1:0] r_sc_pidx, r_rstart;
    logic [6:0]    r_run;
    t_scan         r_kind;

    logic mem_kv [POOL_PAGES];
    logic mem_uv [POOL_PAGES];
    logic mem_kf [POOL_PAGES];
    logic mem_uf [POOL_PAGES];
    logic mem_tp [DIR_ENTRIES];
    logic r_rd_kv, r_rd_uv, r_rd_kf, r_rd_uf, r_rd_tp;

    logic [LW-1:0] kn, un, uvn, vn, fn, sc_len;
    logic [31:0] vbase, fbase, idx32, va, ta_now, pa_now;
    logic [IW-1:0] vwr_addr, rd_addr;
    logic [DIR_W-1:0] dir;
    logic [6:0] ecnt;
    logic rbit, found_now, fail_now, clr_pool, clr_tp;

    function automatic logic [LW-1:0] size_of(input logic [10:0] v, input logic round8);
        logic [SW-1:0] ve;
        logic [SW-1:0] lim;
        logic [LW-1:0] r;
        ve = SW'(v);
        lim = (ve > SW'(POOL_PAGES)) ? SW'(POOL_PAGES) : ve;
        r = LW'(lim);
        if (round8) r = r & ~LW'(7);
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kpb <= KERNEL_PHYS_RESET;
            r_upb <= '0;
            r_kvb <= '0;
            r_uvb <= '0;
            r_kpp <= '0;
            r_upp <= '0;
            r_uvp <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_KERNEL_PHYS_BASE: r_kpb <= i_cfg_data;
                CFG_USER_PHYS_BASE: r_upb <= i_cfg_data;
                CFG_KERNEL_VIRT_BASE: r_kvb <= i_cfg_data;
                CFG_USER_VIRT_BASE: r_uvb <= i_cfg_data;
                CFG_KERNEL_POOL_PAGES: r_kpp <= i_cfg_data[10:0];
                CFG_USER_POOL_PAGES: r_upp <= i_cfg_data[10:0];
                CFG_USER_VIRT_PAGES: r_uvp <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    assign kn = size_of(r_kpp, 1'b1);
    assign un = size_of(r_upp, 1'b1);
    assign uvn = size_of(r_uvp, 1'b0);
    assign vn = r_user ? uvn : kn;
    assign fn = r_user ? un : kn;
    assign vbase = (r_user ? r_uvb : r_kvb) & PAGE_MASK;
    assign fbase = (r_user ? r_upb : r_kpb) & PAGE_MASK;
    assign ecnt = r_req ? 7'd1 : r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req_type;
            r_user <= i_pool_select;
            r_cnt <= i_page_count;
            r_tgt <= i_target_addr;
        end
        if (i_cmd.pg_clr) begin
            r_pg <= '0;
        end else if (i_cmd.pg_inc) begin
            r_pg <= r_pg + 7'd1;
        end
    end

    assign idx32 = (r_tgt - vbase) >> PAGE_SHIFT;
    assign va = r_req ? (r_tgt & PAGE_MASK)
                      : vbase + ((32'(r_start) + 32'(r_pg)) << PAGE_SHIFT);
    assign dir = va[31:32-DIR_W];
    assign vwr_addr = r_req ? idx32[IW-1:0] : IW'(32'(r_start) + 32'(r_pg));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr) begin
            r_clr_addr <= r_clr_addr + CW'(1);
        end
    end
    assign clr_pool = i_cmd.clr && (32'(r_clr_addr) < 32'(POOL_PAGES));
    assign clr_tp = i_cmd.clr && (32'(r_clr_addr) < 32'(DIR_ENTRIES));

    always_comb begin
        case (r_kind)
            SK_VRUN: sc_len = vn;
            SK_DFRAME: sc_len = fn;
            default: sc_len = kn;
        endcase
        case (r_kind)
            SK_VRUN: rbit = r_user ? r_rd_uv : r_rd_kv;
            SK_DFRAME: rbit = r_user ? r_rd_uf : r_rd_kf;
            default: rbit = r_rd_kf;
        endcase
    end

    always_comb begin
        if (r_kind == SK_VRUN) begin
            found_now = r_sc_act && r_sc_pv && !rbit && (r_run + 7'd1 == r_cnt);
        end else begin
            found_now = r_sc_act && r_sc_pv && !rbit;
        end
    end
    assign fail_now = r_sc_act && !r_sc_pv && (r_sc_addr >= sc_len) && !found_now;
    assign rd_addr = r_sc_addr[IW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sc_act <= 1'b0;
        end else if (i_cmd.scan_start) begin
            r_sc_act <= 1'b1;
        end else if (found_now || fail_now) begin
            r_sc_act <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_kind <= i_cmd.scan_kind;
            r_sc_addr <= '0;
            r_sc_pv <= 1'b0;
            r_run <= '0;
        end else if (r_sc_act) begin
            if (r_sc_addr < sc_len) begin
                r_sc_pv <= 1'b1;
                r_sc_pidx <= r_sc_addr[IW-1:0];
                r_sc_addr <= r_sc_addr + LW'(1);
            end else begin
                r_sc_pv <= 1'b0;
            end
            if (r_sc_pv) begin
                if (rbit) begin
                    r_run <= '0;
                end else begin
                    if (r_run == 7'd0) r_rstart <= r_sc_pidx;
                    r_run <= r_run + 7'd1;
                end
            end
        end
        if (found_now && r_kind == SK_VRUN) begin
            r_start <= (r_run == 7'd0) ? r_sc_pidx : r_rstart;
        end
        if (found_now && r_kind == SK_DFRAME) begin
            r_pa <= pa_now;
        end
    end

    assign pa_now = fbase + (32'(r_sc_pidx) << PAGE_SHIFT);
    assign ta_now = (r_kpb & PAGE_MASK) + (32'(r_sc_pidx) << PAGE_SHIFT);

    always_ff @(posedge i_clk) begin
        if (clr_pool) begin
            mem_kv[r_clr_addr[IW-1:0]] <= 1'b0;
        end else if (i_cmd.vwr && !r_user) begin
            mem_kv[vwr_addr] <= 1'b1;
        end
        r_rd_kv <= mem_kv[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (clr_pool) begin
            mem_uv[r_clr_addr[IW-1:0]] <= 1'b0;
        end else if (i_cmd.vwr && r_user) begin
            mem_uv[vwr_addr] <= 1'b1;
        end
        r_rd_uv <= mem_uv[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (clr_pool) begin
            mem_kf[r_clr_addr[IW-1:0]] <= 1'b0;
        end else if (found_now && (r_kind == SK_TFRAME ||
                                   (r_kind == SK_DFRAME && !r_user))) begin
            mem_kf[r_sc_pidx] <= 1'b1;
        end
        r_rd_kf <= mem_kf[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (clr_pool) begin
            mem_uf[r_clr_addr[IW-1:0]] <= 1'b0;
        end else if (found_now && r_kind == SK_DFRAME && r_user) begin
            mem_uf[r_sc_pidx] <= 1'b1;
        end
        r_rd_uf <= mem_uf[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (clr_tp) begin
            mem_tp[r_clr_addr[DIR_W-1:0]] <= 1'b0;
        end else if (found_now && r_kind == SK_TFRAME) begin
            mem_tp[dir] <= 1'b1;
        end
        r_rd_tp <= mem_tp[dir];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_status <= i_cmd.out_st;
            case (i_cmd.out_st)
                ST_OK: begin
                    o_virt_addr <= va;
                    o_phys_addr <= r_pa;
                    o_entry_word <= r_pa | ENTRY_FLAGS;
                    o_table_created <= i_cmd.out_tc;
                    o_table_entry_word <= i_cmd.out_tc ? (ta_now | ENTRY_FLAGS) : '0;
                    o_last <= r_req || (r_pg == r_cnt - 7'd1);
                end
                ST_NO_FRAME: begin
                    o_virt_addr <= va;
                    o_phys_addr <= '0;
                    o_entry_word <= '0;
                    o_table_created <= 1'b0;
                    o_table_entry_word <= '0;
                    o_last <= 1'b1;
                end
                ST_NO_TABLE: begin
                    o_virt_addr <= va;
                    o_phys_addr <= r_pa;
                    o_entry_word <= '0;
                    o_table_created <= 1'b0;
                    o_table_entry_word <= '0;
                    o_last <= 1'b1;
                end
                default: begin
                    o_virt_addr <= '0;
                    o_phys_addr <= '0;
                    o_entry_word <= '0;
                    o_table_created <= 1'b0;
                    o_table_entry_word <= '0;
                    o_last <= 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        o_stat.clr_done = (r_clr_addr == CW'(CLR_N - 1));
        o_stat.is_claim = r_req;
        o_stat.claim_oob = (idx32 >= 32'(vn));
        o_stat.bad_cnt = (r_cnt == 7'd0) || (r_cnt > 7'(MAX_RUN_PAGES));
        o_stat.scan_found = found_now;
        o_stat.scan_fail = fail_now;
        o_stat.vset_done = (r_pg == ecnt - 7'd1);
        o_stat.tpres_bit = r_rd_tp;
        o_stat.out_last = o_last;
    end

endmodule

@@ hdl/bitmap_page_frame_allocator.sv @@
// Top level of the bitmap page frame allocator.
//
// Requests arrive on the input channel (i_valid, o_stall) and each one gives
// one or more results on the output channel (o_valid, i_stall); the final
// result of a request carries o_last. A transfer happens at a rising edge with
// valid high and stall low. Configuration registers are written over the
// i_cfg_valid / o_cfg_ready channel, which is always ready.
// One request is handled at a time. A run request scans the selected virtual
// map one bit per cycle, then sets the bits of the run found, page by page.
// Each page then scans the frame map of its pool from the start, one bit per
// cycle, and, when its directory entry is absent, scans the kernel frame map
// the same way. All maps are single bit memories with one read and one write
// per cycle; that read port sets the pace.
// After reset the block clears its bitmaps, one entry per cycle up to the
// larger of POOL_PAGES and 1024 entries, and holds o_stall high meanwhile.
// A result waits in the output register while the receiver stalls.
module bitmap_page_frame_allocator #(
    parameter int POOL_PAGES = 1024,
    parameter int MAX_RUN_PAGES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_req_type,
    input  logic        i_pool_select,
    input  logic [6:0]  i_page_count,
    input  logic [31:0] i_target_addr,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [31:0] o_virt_addr,
    output logic [31:0] o_phys_addr,
    output logic [31:0] o_entry_word,
    output logic        o_table_created,
    output logic [31:0] o_table_entry_word,
    output logic        o_last
);
    import bpfa_pkg::*;

    t_bpfa_cmd  cmd;
    t_bpfa_stat stat;

    assign o_cfg_ready = 1'b1;

    bpfa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    bpfa_dp #(
        .POOL_PAGES    (POOL_PAGES),
        .MAX_RUN_PAGES (MAX_RUN_PAGES)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_req_type         (i_req_type),
        .i_pool_select      (i_pool_select),
        .i_page_count       (i_page_count),
        .i_target_addr      (i_target_addr),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .o_status           (o_status),
        .o_virt_addr        (o_virt_addr),
        .o_phys_addr        (o_phys_addr),
        .o_entry_word       (o_entry_word),
        .o_table_created    (o_table_created),
        .o_table_entry_word (o_table_entry_word),
        .o_last             (o_last)
    );

endmodule

@@ test/tb_bitmap_page_frame_allocator.sv @@
// Self-checking testbench for the bitmap page frame allocator, with a predictor and random traffic.
module tb_bitmap_page_frame_allocator;
    import bpfa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic        req;
        logic        pool;
        logic [6:0]  cnt;
        logic [31:0] tgt;
    } t_request;

    typedef struct {
        t_status     st;
        logic [31:0] va;
        logic [31:0] pa;
        logic [31:0] ent;
        logic        tc;
        logic [31:0] te;
        logic        last;
    } t_page_result;

    localparam int MAP_BITS = 1024;
    localparam int RUN_LIMIT = 64;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_req_type = 1'b0;
    logic        i_pool_select = 1'b0;
    logic [6:0]  i_page_count = '0;
    logic [31:0] i_target_addr = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [2:0]  o_status;
    logic [31:0] o_virt_addr;
    logic [31:0] o_phys_addr;
    logic [31:0] o_entry_word;
    logic        o_table_created;
    logic [31:0] o_table_entry_word;
    logic        o_last;

    bitmap_page_frame_allocator i_dut (.*);

    always #5 i_clk = ~i_clk;

    // Predictor state; index 0 is the kernel pool, index 1 the user pool.
    logic [31:0] phys_base [2];
    logic [31:0] virt_base [2];
    logic [10:0] kern_pages, user_pages, user_vpages;
    bit          virt_map [2][MAP_BITS];
    bit          frame_map [2][MAP_BITS];
    bit          dir_present [MAP_BITS];

    t_request     pending_reqs [$];
    t_page_result expected_pages [$];
    bit           failed = 1'b0;
    int           drv_cnt = 0;
    int           acc_cnt = 0;
    int           burst_left = 0;
    int           gap_left = 0;
    int           stall_left = 0;

    function automatic int page_limit(logic [10:0] v, bit round8);
        int n;
        n = (v > MAP_BITS) ? MAP_BITS : int'(v);
        if (round8) n = n & ~7;
        return n;
    endfunction

    function automatic int virt_size(int p);
        return p ? page_limit(user_vpages, 1'b0) : page_limit(kern_pages, 1'b1);
    endfunction

    function automatic int frame_size(int p);
        return p ? page_limit(user_pages, 1'b1) : page_limit(kern_pages, 1'b1);
    endfunction

    function automatic bit grab_frame(int p, output logic [31:0] addr);
        int n;
        n = frame_size(p);
        addr = '0;
        for (int i = 0; i < n; i++) begin
            if (!frame_map[p][i]) begin
                frame_map[p][i] = 1'b1;
                addr = (phys_base[p] & PAGE_MASK) + 32'(i) * 32'd4096;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic void push_page(t_status st, logic [31:0] va, logic [31:0] pa,
                                      logic [31:0] ent, logic tc, logic [31:0] te,
                                      logic last);
        t_page_result r;
        r.st = st;
        r.va = va;
        r.pa = pa;
        r.ent = ent;
        r.tc = tc;
        r.te = te;
        r.last = last;
        expected_pages.push_back(r);
    endfunction

    function automatic t_status map_page(int p, logic [31:0] va, bit last);
        logic [31:0] pa, ta;
        logic [9:0]  dir;
        logic        tc;
        logic [31:0] te;
        dir = va[31:22];
        tc = 1'b0;
        te = '0;
        if (!grab_frame(p, pa)) begin
            push_page(ST_NO_FRAME, va, '0, '0, 1'b0, '0, 1'b1);
            return ST_NO_FRAME;
        end
        if (!dir_present[dir]) begin
            if (!grab_frame(0, ta)) begin
                push_page(ST_NO_TABLE, va, pa, '0, 1'b0, '0, 1'b1);
                return ST_NO_TABLE;
            end
            dir_present[dir] = 1'b1;
            tc = 1'b1;
            te = ta | ENTRY_FLAGS;
        end
        push_page(ST_OK, va, pa, pa | ENTRY_FLAGS, tc, te, last);
        return ST_OK;
    endfunction

    function automatic void predict_request(logic req, logic pool, logic [6:0] cnt,
                                            logic [31:0] tgt);
        int          p, vn, run, start;
        bit          found;
        logic [31:0] vb, idx, vstart;
        t_status     st;
        p = pool;
        vn = virt_size(p);
        vb = virt_base[p] & PAGE_MASK;
        run = 0;
        start = 0;
        found = 1'b0;
        if (req) begin
            idx = (tgt - vb) >> PAGE_SHIFT;
            if (idx >= 32'(vn)) begin
                push_page(ST_OUTSIDE, '0, '0, '0, 1'b0, '0, 1'b1);
                return;
            end
            virt_map[p][idx] = 1'b1;
            st = map_page(p, tgt & PAGE_MASK, 1'b1);
            return;
        end
        if (cnt == 0 || cnt > RUN_LIMIT) begin
            push_page(ST_BAD_COUNT, '0, '0, '0, 1'b0, '0, 1'b1);
            return;
        end
        for (int i = 0; i < vn && !found; i++) begin
            if (virt_map[p][i]) begin
                run = 0;
            end else begin
                if (run == 0) start = i;
                run++;
                if (run == int'(cnt)) found = 1'b1;
            end
        end
        if (!found) begin
            push_page(ST_NO_RUN, '0, '0, '0, 1'b0, '0, 1'b1);
            return;
        end
        for (int i = 0; i < int'(cnt); i++) virt_map[p][start + i] = 1'b1;
        vstart = vb + 32'(start) * 32'd4096;
        for (int i = 0; i < int'(cnt); i++) begin
            st = map_page(p, vstart + 32'(i) * 32'd4096, i + 1 == int'(cnt));
            if (st != ST_OK) return;
        end
    endfunction

    // Request driver: bursts with gaps, payload held while stalled.
    always @(negedge i_clk) begin
        t_request q;
        if (!(i_valid && acc_cnt != drv_cnt)) begin
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                q = pending_reqs.pop_front();
                i_req_type <= q.req;
                i_pool_select <= q.pool;
                i_page_count <= q.cnt;
                i_target_addr <= q.tgt;
                i_valid <= 1'b1;
                drv_cnt++;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            acc_cnt++;
            predict_request(i_req_type, i_pool_select, i_page_count, i_target_addr);
        end
    end

    // Result receiver: stall pattern of random stretches, each stalled or not at random.
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_left = $urandom_range(1, 10);
            i_stall <= ($urandom_range(0, 2) == 0);
        end else begin
            stall_left--;
        end
    end

    always @(posedge i_clk) begin
        t_page_result e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_pages.size() == 0) begin
                $display("%0t: unexpected result, status %0d va %h", $time, o_status,
                         o_virt_addr);
                failed = 1'b1;
            end else begin
                e = expected_pages.pop_front();
                if (o_status !== e.st) begin
                    $display("%0t: status expected %0d actual %0d", $time, e.st, o_status);
                    failed = 1'b1;
                end
                if (o_virt_addr !== e.va) begin
                    $display("%0t: virt_addr expected %h actual %h", $time, e.va, o_virt_addr);
                    failed = 1'b1;
                end
                if (o_phys_addr !== e.pa) begin
                    $display("%0t: phys_addr expected %h actual %h", $time, e.pa, o_phys_addr);
                    failed = 1'b1;
                end
                if (o_entry_word !== e.ent) begin
                    $display("%0t: entry_word expected %h actual %h", $time, e.ent,
                             o_entry_word);
                    failed = 1'b1;
                end
                if (o_table_created !== e.tc) begin
                    $display("%0t: table_created expected %0d actual %0d", $time, e.tc,
                             o_table_created);
                    failed = 1'b1;
                end
                if (o_table_entry_word !== e.te) begin
                    $display("%0t: table_entry_word expected %h actual %h", $time, e.te,
                             o_table_entry_word);
                    failed = 1'b1;
                end
                if (o_last !== e.last) begin
                    $display("%0t: last expected %0d actual %0d", $time, e.last, o_last);
                    failed = 1'b1;
                end
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_KERNEL_PHYS_BASE:  phys_base[0] = data;
            CFG_USER_PHYS_BASE:    phys_base[1] = data;
            CFG_KERNEL_VIRT_BASE:  virt_base[0] = data;
            CFG_USER_VIRT_BASE:    virt_base[1] = data;
            CFG_KERNEL_POOL_PAGES: kern_pages = data[10:0];
            CFG_USER_POOL_PAGES:   user_pages = data[10:0];
            CFG_USER_VIRT_PAGES:   user_vpages = data[10:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic setup_pools(logic [31:0] kpb, logic [31:0] upb, logic [31:0] kvb,
                               logic [31:0] uvb, logic [10:0] kpp, logic [10:0] upp,
                               logic [10:0] uvp);
        write_reg(CFG_KERNEL_PHYS_BASE, kpb);
        write_reg(CFG_USER_PHYS_BASE, upb);
        write_reg(CFG_KERNEL_VIRT_BASE, kvb);
        write_reg(CFG_USER_VIRT_BASE, uvb);
        write_reg(CFG_KERNEL_POOL_PAGES, {21'd0, kpp});
        write_reg(CFG_USER_POOL_PAGES, {21'd0, upp});
        write_reg(CFG_USER_VIRT_PAGES, {21'd0, uvp});
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_reqs.size() != 0 || expected_pages.size() != 0 || i_valid);
        repeat (50) @(posedge i_clk);
    endtask

    function automatic void add_req(logic req, logic pool, logic [6:0] cnt,
                                    logic [31:0] tgt);
        t_request q;
        q.req = req;
        q.pool = pool;
        q.cnt = cnt;
        q.tgt = tgt;
        pending_reqs.push_back(q);
    endfunction

    function automatic logic [31:0] inside_addr(int p);
        int n;
        n = virt_size(p);
        if (n == 0) return $urandom;
        return (virt_base[p] & PAGE_MASK) + 32'($urandom_range(0, n - 1)) * 32'd4096
               + 32'($urandom_range(0, 4095));
    endfunction

    function automatic void add_random(int n);
        logic [6:0] c;
        int         k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 99);
            if (k < 55) c = 7'($urandom_range(1, 4));
            else if (k < 63) c = 7'($urandom_range(5, 64));
            else if (k < 68) c = ($urandom_range(0, 1)) ? 7'd0 : 7'($urandom_range(65, 127));
            else c = 7'($urandom);
            if (k < 63 || (k >= 63 && k < 68)) begin
                add_req(1'b0, 1'($urandom), c, $urandom);
            end else if (k < 90) begin
                add_req(1'b1, 1'($urandom), c, inside_addr($urandom_range(0, 1)));
            end else begin
                add_req(1'b1, 1'($urandom), c, $urandom);
            end
        end
    endfunction

    initial begin
        phys_base[0] = KERNEL_PHYS_RESET;
        phys_base[1] = '0;
        virt_base[0] = '0;
        virt_base[1] = '0;
        kern_pages = '0;
        user_pages = '0;
        user_vpages = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        setup_pools(32'h0020_0abc, 32'h1000_0fff, 32'hc000_0123, 32'h0040_0000,
                    11'd64, 11'd64, 11'd64);
        add_req(1'b0, 1'b0, 7'd1, 32'h0);
        add_req(1'b0, 1'b0, 7'd0, 32'hffff_ffff);
        add_req(1'b0, 1'b0, 7'd65, 32'h0);
        add_req(1'b0, 1'b1, 7'd127, 32'h0);
        add_req(1'b1, 1'b0, 7'd127, 32'hc000_0000);
        add_req(1'b1, 1'b0, 7'd0, 32'hc000_0000);
        add_req(1'b1, 1'b0, 7'd3, 32'hc003_ffff);
        add_req(1'b1, 1'b0, 7'd3, 32'hc004_0000);
        add_req(1'b1, 1'b0, 7'd3, 32'hbfff_ffff);
        add_req(1'b1, 1'b1, 7'd1, 32'hffff_ffff);
        add_req(1'b0, 1'b1, 7'd64, 32'h0);
        add_req(1'b0, 1'b1, 7'd1, 32'h0);
        add_req(1'b1, 1'b1, 7'd1, 32'h0040_5123);
        add_req(1'b0, 1'b0, 7'd64, 32'h0);
        add_req(1'b0, 1'b0, 7'd60, 32'h0);
        add_req(1'b1, 1'b0, 7'd1, 32'hc000_1000);
        add_req(1'b1, 1'b0, 7'd1, 32'hc001_0000);
        wait_drained();

        setup_pools(32'h0, 32'h0, 32'h0, 32'h0, 11'd0, 11'd0, 11'd0);
        add_req(1'b0, 1'b0, 7'd1, 32'h0);
        add_req(1'b0, 1'b1, 7'd2, 32'h0);
        add_req(1'b1, 1'b0, 7'd1, 32'h0);
        add_req(1'b1, 1'b1, 7'd1, 32'h0);
        wait_drained();

        // The user pool gets fresh frames above the old ones so the maps reach new entries.
        setup_pools(32'hffff_f000, 32'h8000_0000, 32'hffff_ffff, 32'h7fc0_0000,
                    11'h7ff, 11'd1024, 11'd1024);
        add_req(1'b1, 1'b0, 7'd0, 32'hffff_f000);
        add_req(1'b1, 1'b0, 7'd0, 32'h003f_f000);
        add_req(1'b1, 1'b0, 7'd0, 32'h0040_0000);
        add_req(1'b1, 1'b1, 7'd0, 32'h7fc0_0000);
        add_req(1'b1, 1'b1, 7'd0, 32'h7fff_ffff);
        add_random(38);
        wait_drained();

        setup_pools($urandom, $urandom, $urandom, $urandom, 11'd13, 11'd100, 11'd100);
        add_random(30);
        wait_drained();

        setup_pools(32'h0000_1000, 32'h0010_0000, 32'h0800_0000, 32'h0900_0000,
                    11'd512, 11'd1023, 11'd700);
        add_random(36);
        wait_drained();

        if (!failed) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #2000ms;
        $display("status: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/bpfa_pkg.sv
hdl/bpfa_ctrl.sv
hdl/bpfa_dp.sv
hdl/bitmap_page_frame_allocator.sv
test/tb_bitmap_page_frame_allocator.sv
